/* sv/spectral_sharpen_dehalo_macros.svh */
// Assertion macros used by the checker of the sharpen and dehalo stage.
`ifndef SPECTRAL_SHARPEN_DEHALO_MACROS_SVH
`define SPECTRAL_SHARPEN_DEHALO_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSDH_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ssdh check failed");

// The consequent must hold in the cycle after the antecedent.
`define SSDH_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ssdh check failed");

`endif

/* sv/ssdh_pkg.sv */
// Shared widths, register indexes and fixed-point constants of the sharpen and dehalo stage.
`timescale 1ns / 1ps
package ssdh_pkg;

   localparam int BIN_W      = 24;
   localparam int WGT_W      = 17;
   localparam int OUT_W      = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;
   localparam int GN_W       = 41;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SHARPEN_GAIN  = 3'd0,
      CSR_SIGMA_MIN     = 3'd1,
      CSR_SIGMA_MAX     = 3'd2,
      CSR_DEHALO_GAIN   = 3'd3,
      CSR_HALO_THRESH   = 3'd4,
      CSR_DEGRID_GAIN   = 3'd5
   } csr_index_type;

   localparam logic [31:0]        ONE_Q31 = 32'h8000_0000;
   localparam logic signed [35:0] ONE_Q30 = 36'sd1073741824;

endpackage

/* sv/spectral_sharpen_dehalo.sv */
// Throughput: one word per cycle unless the rsp channel stalls; every long division
// and the square root advance one quotient or root bit per pipeline stage, so no unit
// is shared between words.
// A stalled rsp channel freezes the whole pipeline and drops req_ready in the same cycle.
// Reset clears all valid bits, the configuration registers and the latched grid fraction.
`timescale 1ns / 1ps
module spectral_sharpen_dehalo #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [ssdh_pkg::BIN_W-1:0]       req_bin_re,
   input  logic signed [ssdh_pkg::BIN_W-1:0]       req_bin_im,
   input  logic [ssdh_pkg::WGT_W-1:0]              req_sharpen_weight,
   input  logic [ssdh_pkg::WGT_W-1:0]              req_dehalo_weight,
   input  logic signed [ssdh_pkg::BIN_W-1:0]       req_grid_re,
   input  logic signed [ssdh_pkg::BIN_W-1:0]       req_grid_im,
   input  logic                                    req_first_in_block,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [ssdh_pkg::OUT_W-1:0]       rsp_out_re,
   output logic signed [ssdh_pkg::OUT_W-1:0]       rsp_out_im,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [ssdh_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [ssdh_pkg::CSR_DATA_W-1:0]         csr_data
);
   import ssdh_pkg::*;

   localparam int SB  = SAMPLE_BITS;
   localparam int OB  = (SB < OUT_W) ? SB : OUT_W;
   localparam int PW  = 2 * SB;
   localparam int PRW = SB + 34;

   localparam logic signed [67:0] SB_HI = (68'sd1 <<< (SB - 1)) - 68'sd1;
   localparam logic signed [67:0] SB_LO = -SB_HI - 68'sd1;
   localparam logic signed [67:0] OB_HI = (68'sd1 <<< (OB - 1)) - 68'sd1;
   localparam logic signed [67:0] OB_LO = -OB_HI - 68'sd1;

   // Pipeline stage map.
   localparam int S_GN     = 1;
   localparam int S_GD0    = 2;
   localparam int GD_STEPS = GN_W;
   localparam int S_FR     = S_GD0 + GD_STEPS;
   localparam int S_CP     = S_FR + 1;
   localparam int S_CR     = S_CP + 1;
   localparam int S_CU     = S_CR + 1;
   localparam int S_SQ     = S_CU + 1;
   localparam int S_PS     = S_SQ + 1;
   localparam int S_PR     = S_PS + 1;
   localparam int S_HP     = S_PR + 1;
   localparam int S_HS     = S_HP + 1;
   localparam int S_DN     = S_HS + 1;
   localparam int S_DV0    = S_DN + 1;
   localparam int DV_STEPS = 31;
   localparam int S_RF     = S_DV0 + DV_STEPS;
   localparam int S_SR0    = S_RF + 1;
   localparam int SR_STEPS = 17;
   localparam int S_M2     = S_SR0 + SR_STEPS;
   localparam int S_M3     = S_M2 + 1;
   localparam int S_M4     = S_M3 + 1;
   localparam int S_M5     = S_M4 + 1;
   localparam int S_M6     = S_M5 + 1;
   localparam int S_OUT    = S_M6 + 1;
   localparam int NST      = S_OUT + 1;

   typedef struct packed {
      logic signed [BIN_W-1:0] bre;
      logic signed [BIN_W-1:0] bim;
      logic signed [BIN_W-1:0] gre;
      logic signed [BIN_W-1:0] gim;
      logic [WGT_W-1:0]        ws;
      logic [WGT_W-1:0]        wd;
      logic                    first;
      logic [GN_W-1:0]         gnq;
      logic [BIN_W-1:0]        grem;
      logic [BIN_W-1:0]        gd;
      logic                    gneg;
      logic                    gzero;
      logic [31:0]             fmag;
      logic                    fneg;
      logic [55:0]             cp_re;
      logic [55:0]             cp_im;
      logic                    cpn_re;
      logic                    cpn_im;
      logic signed [SB-1:0]    cre;
      logic signed [SB-1:0]    cim;
      logic                    ure_n;
      logic                    uim_n;
      logic [SB-1:0]           are;
      logic [SB-1:0]           aim;
      logic [PW-1:0]           sq_re;
      logic [PW-1:0]           sq_im;
      logic [63:0]             psd;
      logic [63:0]             d1;
      logic [63:0]             d2;
      logic [63:0]             num;
      logic [63:0]             den;
      logic [20:0]             k16;
      logic [32:0]             t1;
      logic [52:0]             hp_hi;
      logic [52:0]             hp_lo;
      logic [63:0]             halo;
      logic                    c1;
      logic                    c2;
      logic                    cd;
      logic                    rz;
      logic [63:0]             rm1;
      logic [63:0]             rm2;
      logic [63:0]             rmd;
      logic [30:0]             q1;
      logic [30:0]             q2;
      logic [30:0]             qd;
      logic [31:0]             fd;
      logic [32:0]             sv;
      logic [32:0]             sr;
      logic [49:0]             t2;
      logic                    fs_n;
      logic [33:0]             fs_m;
      logic [63:0]             fm2;
      logic                    f_n;
      logic [33:0]             f_m;
      logic [PRW-1:0]          pr_re;
      logic [PRW-1:0]          pr_im;
      logic [OUT_W-1:0]        ore;
      logic [OUT_W-1:0]        oim;
   } st_type;

   // Configuration registers.
   logic signed [15:0] sg_ff;
   logic [47:0]        smin_ff;
   logic [47:0]        smax_ff;
   logic [15:0]        dhg_ff;
   logic [47:0]        ht_ff;
   logic [16:0]        dg_ff;
   logic signed [31:0] grid_fraction_ff;

   logic [NST-1:0] vld_ff;
   logic [NST-1:0] vld_in;
   st_type         st_ff [NST];
   st_type         st_in [NST];
   logic           adv;
   logic [15:0]    gm;
   logic signed [31:0] frac_new;

   function automatic logic [BIN_W-1:0] mag_bin(input logic signed [BIN_W-1:0] v);
      logic [BIN_W-1:0] u;
      u = v;
      return u[BIN_W-1] ? (~u + 1'b1) : u;
   endfunction

   function automatic logic signed [SB-1:0] sat_sb(input logic signed [67:0] v);
      logic signed [67:0] c;
      c = (v > SB_HI) ? SB_HI : ((v < SB_LO) ? SB_LO : v);
      return c[SB-1:0];
   endfunction

   function automatic logic [OUT_W-1:0] sat_ob(input logic signed [67:0] v);
      logic signed [67:0] c;
      c = (v > OB_HI) ? OB_HI : ((v < OB_LO) ? OB_LO : v);
      return c[OUT_W-1:0];
   endfunction

   // Rounds a 16-fraction-bit magnitude half away from zero, applies the sign, saturates.
   function automatic logic signed [SB-1:0] corr_val(input logic [55:0] cp, input logic n);
      logic [40:0]        rr;
      logic signed [67:0] v;
      rr = 41'((57'(cp) + 57'd32768) >> 16);
      v  = n ? -$signed(68'(rr)) : $signed(68'(rr));
      return sat_sb(v);
   endfunction

   function automatic logic [SB-1:0] mag_sb(input logic signed [SB-1:0] v);
      logic [SB-1:0] u;
      u = v;
      return u[SB-1] ? (~u + 1'b1) : u;
   endfunction

   // One restoring step of a fractional division with the remainder below the divisor.
   function automatic logic [94:0] div_step(input logic [63:0] rm, input logic [63:0] d,
                                            input logic [30:0] q);
      logic [64:0] t;
      t = {rm, 1'b0};
      if (t >= {1'b0, d}) begin
         return {64'(t - {1'b0, d}), q[29:0], 1'b1};
      end else begin
         return {t[63:0], q[29:0], 1'b0};
      end
   endfunction

   function automatic logic [OUT_W-1:0] out_val(input logic [PRW-1:0] pr, input logic n,
                                                input logic signed [SB-1:0] c);
      logic [67:0]        rr;
      logic signed [67:0] v;
      rr = (68'(pr) + 68'd536870912) >> 30;
      v  = n ? -$signed(rr) : $signed(rr);
      v  = v + 68'(c);
      return sat_ob(v);
   endfunction

   assign csr_ready = 1'b1;
   assign adv       = !vld_ff[NST-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[NST-1];
   assign rsp_out_re = st_ff[NST-1].ore;
   assign rsp_out_im = st_ff[NST-1].oim;
   assign vld_in    = {vld_ff[NST-2:0], req_valid};
   assign gm        = sg_ff[15] ? 16'(-sg_ff) : 16'(sg_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sg_ff   <= '0;
         smin_ff <= '0;
         smax_ff <= '0;
         dhg_ff  <= '0;
         ht_ff   <= '0;
         dg_ff   <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SHARPEN_GAIN: sg_ff   <= csr_data[15:0];
            CSR_SIGMA_MIN:    smin_ff <= csr_data;
            CSR_SIGMA_MAX:    smax_ff <= csr_data;
            CSR_DEHALO_GAIN:  dhg_ff  <= csr_data[15:0];
            CSR_HALO_THRESH:  ht_ff   <= csr_data;
            CSR_DEGRID_GAIN:  dg_ff   <= csr_data[16:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff <= st_in;
      end
   end

   // The grid fraction is latched in word order as the first word of a block passes.
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_fraction_ff <= '0;
      end else if (adv && vld_ff[S_FR-1] && st_ff[S_FR-1].first) begin
         grid_fraction_ff <= frac_new;
      end
   end

   always_comb begin
      st_type s;
      s       = '0;
      s.bre   = req_bin_re;
      s.bim   = req_bin_im;
      s.ws    = req_sharpen_weight;
      s.wd    = req_dehalo_weight;
      s.gre   = req_grid_re;
      s.gim   = req_grid_im;
      s.first = req_first_in_block;
      st_in[0] = s;
   end

   always_comb begin
      st_type s;
      s       = st_ff[S_GN-1];
      s.gnq   = 41'(dg_ff) * 41'(mag_bin(s.bre));
      s.gd    = mag_bin(s.gre);
      s.gneg  = s.bre[BIN_W-1] ^ s.gre[BIN_W-1];
      s.gzero = (s.gre == '0);
      s.grem  = '0;
      st_in[S_GN] = s;
   end

   // Long division of the degrid numerator by the grid magnitude, one bit per stage.
   for (genvar g = 0; g < GD_STEPS; g++) begin : g_gdiv
      always_comb begin
         st_type         s;
         logic [BIN_W:0] t;
         s = st_ff[S_GD0+g-1];
         t = {s.grem, s.gnq[GN_W-1]};
         if (t >= {1'b0, s.gd}) begin
            s.grem = BIN_W'(t - {1'b0, s.gd});
            s.gnq  = {s.gnq[GN_W-2:0], 1'b1};
         end else begin
            s.grem = t[BIN_W-1:0];
            s.gnq  = {s.gnq[GN_W-2:0], 1'b0};
         end
         st_in[S_GD0+g] = s;
      end
   end

   always_comb begin
      logic [GN_W-1:0] q;
      q = st_ff[S_FR-1].gnq;
      if (st_ff[S_FR-1].gzero) begin
         frac_new = '0;
      end else if (st_ff[S_FR-1].gneg) begin
         frac_new = (q > 41'h0_8000_0000) ? 32'sh8000_0000 : $signed(~q[31:0] + 32'd1);
      end else begin
         frac_new = (q > 41'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
      end
   end

   always_comb begin
      st_type             s;
      logic signed [31:0] fsel;
      s      = st_ff[S_FR-1];
      fsel   = s.first ? frac_new : grid_fraction_ff;
      s.fneg = fsel[31];
      s.fmag = fsel[31] ? (~fsel + 32'd1) : fsel;
      st_in[S_FR] = s;
   end

   always_comb begin
      st_type s;
      s        = st_ff[S_CP-1];
      s.cp_re  = 56'(s.fmag) * 56'(mag_bin(s.gre));
      s.cp_im  = 56'(s.fmag) * 56'(mag_bin(s.gim));
      s.cpn_re = s.fneg ^ s.gre[BIN_W-1];
      s.cpn_im = s.fneg ^ s.gim[BIN_W-1];
      st_in[S_CP] = s;
   end

   always_comb begin
      st_type s;
      s     = st_ff[S_CR-1];
      s.cre = corr_val(s.cp_re, s.cpn_re);
      s.cim = corr_val(s.cp_im, s.cpn_im);
      st_in[S_CR] = s;
   end

   always_comb begin
      st_type            s;
      logic signed [SB-1:0] ure;
      logic signed [SB-1:0] uim;
      s       = st_ff[S_CU-1];
      ure     = sat_sb(68'(s.bre) - 68'(s.cre));
      uim     = sat_sb(68'(s.bim) - 68'(s.cim));
      s.ure_n = ure[SB-1];
      s.uim_n = uim[SB-1];
      s.are   = mag_sb(ure);
      s.aim   = mag_sb(uim);
      st_in[S_CU] = s;
   end

   always_comb begin
      st_type s;
      s       = st_ff[S_SQ-1];
      s.sq_re = PW'(s.are) * PW'(s.are);
      s.sq_im = PW'(s.aim) * PW'(s.aim);
      st_in[S_SQ] = s;
   end

   always_comb begin
      st_type s;
      s     = st_ff[S_PS-1];
      s.psd = 64'(s.sq_re) + 64'(s.sq_im);
      st_in[S_PS] = s;
   end

   always_comb begin
      st_type      s;
      logic [32:0] kp;
      s     = st_ff[S_PR-1];
      s.d1  = s.psd + 64'(smin_ff);
      s.d2  = s.psd + 64'(smax_ff);
      s.num = s.psd + 64'(ht_ff);
      kp    = 33'(dhg_ff) * 33'(s.wd);
      s.k16 = kp[32:12];
      s.t1  = 33'(gm) * 33'(s.ws);
      // A ratio whose numerator reaches its denominator is clamped to one.
      s.c1  = (smin_ff == '0);
      s.c2  = (s.psd == '0);
      s.rz  = (s.psd == '0) && ((smin_ff == '0) || (smax_ff == '0));
      st_in[S_PR] = s;
   end

   always_comb begin
      st_type s;
      s       = st_ff[S_HP-1];
      s.hp_hi = 53'(s.psd[63:32]) * 53'(s.k16);
      s.hp_lo = 53'(s.psd[31:0]) * 53'(s.k16);
      st_in[S_HP] = s;
   end

   always_comb begin
      st_type      s;
      logic [84:0] full;
      s      = st_ff[S_HS-1];
      full   = {s.hp_hi, 32'd0} + 85'(s.hp_lo);
      s.halo = (full[84:80] != '0) ? '1 : full[79:16];
      st_in[S_HS] = s;
   end

   always_comb begin
      st_type      s;
      logic [64:0] dsum;
      s     = st_ff[S_DN-1];
      dsum  = 65'(s.num) + 65'(s.halo);
      s.den = dsum[64] ? '1 : dsum[63:0];
      s.cd  = (s.halo == '0);
      s.rm1 = s.psd;
      s.rm2 = 64'(smax_ff);
      s.rmd = s.num;
      s.q1  = '0;
      s.q2  = '0;
      s.qd  = '0;
      st_in[S_DN] = s;
   end

   // Three fractional dividers side by side, one quotient bit per stage.
   for (genvar g = 0; g < DV_STEPS; g++) begin : g_ratio
      always_comb begin
         st_type s;
         s = st_ff[S_DV0+g-1];
         {s.rm1, s.q1} = div_step(s.rm1, s.d1, s.q1);
         {s.rm2, s.q2} = div_step(s.rm2, s.d2, s.q2);
         {s.rmd, s.qd} = div_step(s.rmd, s.den, s.qd);
         st_in[S_DV0+g] = s;
      end
   end

   always_comb begin
      st_type      s;
      logic [31:0] r1;
      logic [31:0] r2;
      logic [63:0] prod;
      s    = st_ff[S_RF-1];
      r1   = s.c1 ? ONE_Q31 : {1'b0, s.q1};
      r2   = s.c2 ? ONE_Q31 : {1'b0, s.q2};
      prod = 64'(r1) * 64'(r2);
      s.fd = s.cd ? ONE_Q31 : {1'b0, s.qd};
      s.sv = s.rz ? '0 : prod[62:30];
      s.sr = '0;
      st_in[S_RF] = s;
   end

   // Integer square root, one root bit per stage.
   for (genvar g = 0; g < SR_STEPS; g++) begin : g_sqrt
      localparam logic [32:0] SQ_B = 33'(64'd1 << (32 - 2 * g));
      always_comb begin
         st_type s;
         s = st_ff[S_SR0+g-1];
         if (s.sv >= s.sr + SQ_B) begin
            s.sv = s.sv - (s.sr + SQ_B);
            s.sr = (s.sr >> 1) + SQ_B;
         end else begin
            s.sr = s.sr >> 1;
         end
         st_in[S_SR0+g] = s;
      end
   end

   always_comb begin
      st_type s;
      s    = st_ff[S_M2-1];
      s.t2 = 50'(s.t1) * 50'(s.sr[16:0]);
      st_in[S_M2] = s;
   end

   always_comb begin
      st_type             s;
      logic [34:0]        rr;
      logic signed [35:0] fsv;
      logic signed [35:0] fabs;
      s      = st_ff[S_M3-1];
      rr     = 35'((51'(s.t2) + 51'd32768) >> 16);
      fsv    = ONE_Q30 + (sg_ff[15] ? -$signed(36'(rr)) : $signed(36'(rr)));
      fabs   = fsv[35] ? -fsv : fsv;
      s.fs_n = fsv[35];
      s.fs_m = fabs[33:0];
      st_in[S_M3] = s;
   end

   always_comb begin
      st_type      s;
      logic [65:0] p;
      s     = st_ff[S_M4-1];
      p     = 66'(s.fs_m) * 66'(s.fd);
      s.fm2 = p[63:0];
      st_in[S_M4] = s;
   end

   always_comb begin
      st_type s;
      s     = st_ff[S_M5-1];
      s.f_m = 34'((65'(s.fm2) + 65'd1073741824) >> 31);
      s.f_n = s.fs_n;
      st_in[S_M5] = s;
   end

   always_comb begin
      st_type s;
      s       = st_ff[S_M6-1];
      s.pr_re = PRW'(s.are) * PRW'(s.f_m);
      s.pr_im = PRW'(s.aim) * PRW'(s.f_m);
      st_in[S_M6] = s;
   end

   always_comb begin
      st_type s;
      s = st_ff[S_OUT-1];
      // With both gains off the word passes through untouched by the correction.
      if (sg_ff == '0 && dhg_ff == '0) begin
         s.ore = sat_ob(68'(s.bre));
         s.oim = sat_ob(68'(s.bim));
      end else begin
         s.ore = out_val(s.pr_re, s.ure_n ^ s.f_n, s.cre);
         s.oim = out_val(s.pr_im, s.uim_n ^ s.f_n, s.cim);
      end
      st_in[S_OUT] = s;
   end

endmodule

/* sv/ssdh_checker.sv */
// Port-level checker of the sharpen and dehalo stage, bound to the top level.
`timescale 1ns / 1ps
`include "spectral_sharpen_dehalo_macros.svh"
module ssdh_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [ssdh_pkg::OUT_W-1:0]   rsp_out_re,
   input logic signed [ssdh_pkg::OUT_W-1:0]   rsp_out_im
);

   `SSDH_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `SSDH_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_out_re) && $stable(rsp_out_im))
   // A stalled result word must stall the input side in the same cycle.
   `SSDH_ASSERT_NOW(a_stall_back, rsp_valid && !rsp_ready, !req_ready)
   // With the output stage empty the pipeline always moves.
   `SSDH_ASSERT_NOW(a_empty_moves, !rsp_valid, req_ready)

endmodule

bind spectral_sharpen_dehalo ssdh_checker u_ssdh_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_out_re (rsp_out_re),
   .rsp_out_im (rsp_out_im)
);
